// ===== hw/rtl/i2cm_pkg.sv =====
`default_nettype none
package i2cm_pkg;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_PHASE = CFG_IDX_W'(1);

  localparam logic [7:0] ACK_TIMEOUT_RST     = 8'd250;
  localparam logic [7:0] TICKS_PER_PHASE_RST = 8'd1;

  typedef enum logic [2:0] {
    FN_TICK     = 3'd0,
    FN_START    = 3'd1,
    FN_STOP     = 3'd2,
    FN_SEND     = 3'd3,
    FN_READ     = 3'd4,
    FN_WAIT_ACK = 3'd5
  } func_t;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_A    = 5'd1,
    PH_ST_B    = 5'd2,
    PH_SP_A    = 5'd3,
    PH_SP_B    = 5'd4,
    PH_TX_HI   = 5'd5,
    PH_TX_LO   = 5'd6,
    PH_RX_LO   = 5'd7,
    PH_RX_HI   = 5'd8,
    PH_AK_LO   = 5'd9,
    PH_AK_HI   = 5'd10,
    PH_WA_A    = 5'd11,
    PH_WA_B    = 5'd12,
    PH_WA_POLL = 5'd13
  } phase_t;

endpackage
`default_nettype wire

// ===== hw/rtl/i2cm_in_if.sv =====
`default_nettype none
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] data_byte;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, func, data_byte, send_ack, sda_in, input ready);
  modport sink (input valid, func, data_byte, send_ack, sda_in, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/i2cm_out_if.sv =====
`default_nettype none
interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_level;
  logic       sda_level;
  logic       sda_driven;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_missing;
  logic       rejected;

  modport source (
    output valid, scl_level, sda_level, sda_driven, busy_res, done_res, rx_byte,
           ack_missing, rejected,
    input  ready
  );
  modport sink (
    input  valid, scl_level, sda_level, sda_driven, busy_res, done_res, rx_byte,
           ack_missing, rejected,
    output ready
  );
endinterface
`default_nettype wire

// ===== hw/rtl/i2cm_cfg_if.sv =====
`default_nettype none
interface i2cm_cfg_if;
  import i2cm_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [7:0]           data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/i2c_master_bit_engine.sv =====
// An input word's result word is registered and shows in the cycle after acceptance.
// Throughput: one word per cycle unless a result waits untaken; the sequencer steps
// at most once per word, next state from one pass between state and result registers.
// Reset (rst_n low, synchronous): sequencer idle, SCL and SDA high and driven,
// ack_timeout 250, ticks_per_phase 1, no result word pending.
`default_nettype none
module i2c_master_bit_engine (
  input  wire logic clk,
  input  wire logic rst_n,
  i2cm_in_if.sink   in_ch,
  i2cm_out_if.source out_ch,
  i2cm_cfg_if.sink  cfg_ch
);
  import i2cm_pkg::*;

  logic [7:0] ack_timeout_r;
  logic [7:0] ticks_per_phase_r;

  phase_t     phase_r, phase_nxt;
  logic [3:0] bit_index_r, bit_index_nxt;
  logic [7:0] shift_byte_r, shift_byte_nxt;
  logic [7:0] wait_count_r, wait_count_nxt;
  logic [7:0] tick_div_r, tick_div_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       sda_oe_r, sda_oe_nxt;
  logic       ack_flag_r, ack_flag_nxt;
  logic       ack_choice_r, ack_choice_nxt;
  logic [7:0] rx_last_r, rx_last_nxt;
  logic       done_nxt, rej_nxt;

  logic       out_valid_r;
  logic       in_acc;
  logic       idle;
  logic       is_tick;
  logic       is_cmd;
  func_t      func;
  logic [7:0] lim;
  logic [7:0] div_inc;
  logic       per_over;
  logic       last_bit;
  logic       wait_expired;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ack_timeout_r     <= ACK_TIMEOUT_RST;
      ticks_per_phase_r <= TICKS_PER_PHASE_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_ACK_TIMEOUT:     ack_timeout_r     <= cfg_ch.data;
        CFG_TICKS_PER_PHASE: ticks_per_phase_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;

  assign func         = func_t'(in_ch.func);
  assign idle         = (phase_r == PH_IDLE);
  assign is_tick      = (func == FN_TICK);
  assign is_cmd       = (in_ch.func >= 3'(FN_START)) && (in_ch.func <= 3'(FN_WAIT_ACK));
  assign lim          = (ticks_per_phase_r == 8'd0) ? 8'd1 : ticks_per_phase_r;
  assign div_inc      = tick_div_r + 8'd1;
  assign per_over     = (div_inc >= lim);
  assign last_bit     = (bit_index_r >= 4'd7);
  assign wait_expired = (wait_count_r >= ack_timeout_r);

  always_comb begin
    phase_nxt = phase_r;
    if (in_acc && is_tick && !idle) begin
      unique case (phase_r)
        PH_ST_A:  if (per_over) phase_nxt = PH_ST_B;
        PH_ST_B:  if (per_over) phase_nxt = PH_IDLE;
        PH_SP_A:  if (per_over) phase_nxt = PH_SP_B;
        PH_SP_B:  if (per_over) phase_nxt = PH_IDLE;
        PH_TX_HI: if (per_over) phase_nxt = PH_TX_LO;
        PH_TX_LO: if (per_over) phase_nxt = last_bit ? PH_IDLE : PH_TX_HI;
        PH_RX_LO: if (per_over) phase_nxt = PH_RX_HI;
        PH_RX_HI: if (per_over) phase_nxt = last_bit ? PH_AK_LO : PH_RX_LO;
        PH_AK_LO: if (per_over) phase_nxt = PH_AK_HI;
        PH_AK_HI: if (per_over) phase_nxt = PH_IDLE;
        PH_WA_A:  if (per_over) phase_nxt = PH_WA_B;
        PH_WA_B:  if (per_over) phase_nxt = PH_WA_POLL;
        PH_WA_POLL: begin
          if (!in_ch.sda_in) begin
            phase_nxt = PH_IDLE;
          end else if (wait_expired) begin
            phase_nxt = PH_SP_A;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end else if (in_acc && is_cmd && idle) begin
      unique case (func)
        FN_START:    phase_nxt = PH_ST_A;
        FN_STOP:     phase_nxt = PH_SP_A;
        FN_SEND:     phase_nxt = PH_TX_HI;
        FN_READ:     phase_nxt = PH_RX_LO;
        FN_WAIT_ACK: phase_nxt = PH_WA_A;
        default:     phase_nxt = phase_r;
      endcase
    end
  end

  always_comb begin
    bit_index_nxt  = bit_index_r;
    shift_byte_nxt = shift_byte_r;
    wait_count_nxt = wait_count_r;
    tick_div_nxt   = tick_div_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    sda_oe_nxt     = sda_oe_r;
    ack_flag_nxt   = ack_flag_r;
    ack_choice_nxt = ack_choice_r;
    rx_last_nxt    = rx_last_r;
    done_nxt       = 1'b0;
    rej_nxt        = 1'b0;
    if (in_acc && is_tick && !idle) begin
      if (phase_r != PH_WA_POLL) begin
        tick_div_nxt = per_over ? 8'd0 : div_inc;
      end
      unique case (phase_r)
        PH_ST_A:  if (per_over) sda_nxt = 1'b0;
        PH_ST_B: begin
          if (per_over) begin
            scl_nxt  = 1'b0;
            done_nxt = 1'b1;
          end
        end
        PH_SP_A: begin
          if (per_over) begin
            sda_nxt = 1'b1;
            scl_nxt = 1'b1;
          end
        end
        PH_SP_B:  if (per_over) done_nxt = 1'b1;
        PH_TX_HI: if (per_over) scl_nxt = 1'b0;
        PH_TX_LO: begin
          if (per_over) begin
            if (last_bit) begin
              done_nxt = 1'b1;
            end else begin
              bit_index_nxt  = bit_index_r + 4'd1;
              sda_nxt        = shift_byte_r[7];
              shift_byte_nxt = {shift_byte_r[6:0], 1'b0};
              scl_nxt        = 1'b1;
            end
          end
        end
        PH_RX_LO: begin
          if (per_over) begin
            scl_nxt        = 1'b1;
            shift_byte_nxt = {shift_byte_r[6:0], in_ch.sda_in};
          end
        end
        PH_RX_HI: begin
          if (per_over) begin
            scl_nxt = 1'b0;
            if (last_bit) begin
              rx_last_nxt = shift_byte_r;
              sda_oe_nxt  = 1'b1;
              sda_nxt     = !ack_choice_r;
            end else begin
              bit_index_nxt = bit_index_r + 4'd1;
            end
          end
        end
        PH_AK_LO: if (per_over) scl_nxt = 1'b1;
        PH_AK_HI: begin
          if (per_over) begin
            scl_nxt  = 1'b0;
            done_nxt = 1'b1;
          end
        end
        PH_WA_A:  if (per_over) scl_nxt = 1'b1;
        PH_WA_B:  if (per_over) wait_count_nxt = 8'd0;
        PH_WA_POLL: begin
          if (!in_ch.sda_in) begin
            scl_nxt      = 1'b0;
            ack_flag_nxt = 1'b0;
            tick_div_nxt = 8'd0;
            done_nxt     = 1'b1;
          end else if (wait_expired) begin
            ack_flag_nxt = 1'b1;
            sda_oe_nxt   = 1'b1;
            sda_nxt      = 1'b0;
            scl_nxt      = 1'b0;
            tick_div_nxt = 8'd0;
          end else begin
            wait_count_nxt = wait_count_r + 8'd1;
          end
        end
        default: tick_div_nxt = 8'd0;
      endcase
    end else if (in_acc && is_cmd) begin
      if (!idle) begin
        rej_nxt = 1'b1;
      end else begin
        tick_div_nxt  = 8'd0;
        bit_index_nxt = 4'd0;
        unique case (func)
          FN_START: begin
            sda_oe_nxt = 1'b1;
            sda_nxt    = 1'b1;
            scl_nxt    = 1'b1;
          end
          FN_STOP: begin
            sda_oe_nxt = 1'b1;
            sda_nxt    = 1'b0;
            scl_nxt    = 1'b0;
          end
          FN_SEND: begin
            sda_oe_nxt     = 1'b1;
            sda_nxt        = in_ch.data_byte[7];
            shift_byte_nxt = {in_ch.data_byte[6:0], 1'b0};
            scl_nxt        = 1'b1;
          end
          FN_READ: begin
            sda_oe_nxt     = 1'b0;
            sda_nxt        = 1'b1;
            scl_nxt        = 1'b0;
            shift_byte_nxt = 8'd0;
            ack_choice_nxt = in_ch.send_ack;
          end
          FN_WAIT_ACK: begin
            sda_oe_nxt     = 1'b0;
            sda_nxt        = 1'b1;
            ack_flag_nxt   = 1'b0;
            wait_count_nxt = 8'd0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      bit_index_r  <= 4'd0;
      shift_byte_r <= 8'd0;
      wait_count_r <= 8'd0;
      tick_div_r   <= 8'd0;
      scl_r        <= 1'b1;
      sda_r        <= 1'b1;
      sda_oe_r     <= 1'b1;
      ack_flag_r   <= 1'b0;
      ack_choice_r <= 1'b0;
      rx_last_r    <= 8'd0;
      out_valid_r  <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      bit_index_r  <= bit_index_nxt;
      shift_byte_r <= shift_byte_nxt;
      wait_count_r <= wait_count_nxt;
      tick_div_r   <= tick_div_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      sda_oe_r     <= sda_oe_nxt;
      ack_flag_r   <= ack_flag_nxt;
      ack_choice_r <= ack_choice_nxt;
      rx_last_r    <= rx_last_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  logic       done_r;
  logic       rej_r;
  logic       busy_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      done_r <= done_nxt;
      rej_r  <= rej_nxt;
      busy_r <= (phase_nxt != PH_IDLE);
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.scl_level   = scl_r;
  assign out_ch.sda_level   = sda_r;
  assign out_ch.sda_driven  = sda_oe_r;
  assign out_ch.busy_res    = busy_r;
  assign out_ch.done_res    = done_r;
  assign out_ch.rx_byte     = rx_last_r;
  assign out_ch.ack_missing = ack_flag_r;
  assign out_ch.rejected    = rej_r;

endmodule
`default_nettype wire

// ===== bench/tb_i2c_master_bit_engine.sv =====
`timescale 1ns / 100ps
module tb_i2c_master_bit_engine;
  import i2cm_pkg::*;

  // Function codes the block does not define; words carrying them are ignored.
  localparam logic [2:0] FN_SPARE_LO = 3'd6;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;
  localparam int unsigned LONG_HOLD_AT = 150;
  localparam int unsigned LONG_HOLD_CYCLES = 64;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] data_byte;
    logic       send_ack;
    logic       sda_in;
  } bus_word_t;

  typedef struct packed {
    logic       scl;
    logic       sda;
    logic       sda_oe;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       ack_missing;
    logic       rejected;
  } line_state_t;

  logic clk;
  logic rst_n;

  i2cm_in_if  in_if ();
  i2cm_out_if out_if ();
  i2cm_cfg_if cfg_if ();

  i2c_master_bit_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  bus_word_t   pending_words[$];
  line_state_t expected_lines[$];
  bus_word_t   cur_word;
  line_state_t front_line;

  phase_t     seq_phase;
  logic [3:0] bit_idx;
  logic [7:0] shreg;
  logic [7:0] poll_count;
  logic [7:0] div_count;
  logic       scl_q;
  logic       sda_q;
  logic       oe_q;
  logic       nack_q;
  logic       ack_sel;
  logic [7:0] rx_q;
  logic [7:0] cfg_timeout;
  logic [7:0] cfg_tpp;

  int unsigned n_queued;
  int unsigned n_sent;
  int unsigned n_checked;
  int unsigned n_done;
  int unsigned n_rej;
  int unsigned n_timeouts;
  int unsigned n_errors;
  int unsigned gap_left;
  int unsigned hold_left;
  bit          src_burst;
  bit          sink_burst;
  bit          accepted;

  function automatic void goto_phase(phase_t p);
    seq_phase = p;
    div_count = 8'd0;
  endfunction

  function automatic bit half_period_done();
    logic [7:0] lim;
    lim = (cfg_tpp == 8'd0) ? 8'd1 : cfg_tpp;
    div_count = div_count + 8'd1;
    if (div_count >= lim) begin
      div_count = 8'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void shift_out_bit();
    sda_q = shreg[7];
    shreg = {shreg[6:0], 1'b0};
  endfunction

  function automatic void open_stop();
    oe_q = 1'b1;
    sda_q = 1'b0;
    scl_q = 1'b0;
    goto_phase(PH_SP_A);
  endfunction

  function automatic bit clock_tick(logic sda);
    bit ended;
    ended = 1'b0;
    case (seq_phase)
      PH_ST_A: begin
        if (half_period_done()) begin
          sda_q = 1'b0;
          goto_phase(PH_ST_B);
        end
      end
      PH_ST_B: begin
        if (half_period_done()) begin
          scl_q = 1'b0;
          goto_phase(PH_IDLE);
          ended = 1'b1;
        end
      end
      PH_SP_A: begin
        if (half_period_done()) begin
          sda_q = 1'b1;
          scl_q = 1'b1;
          goto_phase(PH_SP_B);
        end
      end
      PH_SP_B: begin
        if (half_period_done()) begin
          goto_phase(PH_IDLE);
          ended = 1'b1;
        end
      end
      PH_TX_HI: begin
        if (half_period_done()) begin
          scl_q = 1'b0;
          goto_phase(PH_TX_LO);
        end
      end
      PH_TX_LO: begin
        if (half_period_done()) begin
          if (bit_idx >= 4'd7) begin
            goto_phase(PH_IDLE);
            ended = 1'b1;
          end else begin
            bit_idx = bit_idx + 4'd1;
            shift_out_bit();
            scl_q = 1'b1;
            goto_phase(PH_TX_HI);
          end
        end
      end
      PH_RX_LO: begin
        if (half_period_done()) begin
          scl_q = 1'b1;
          shreg = {shreg[6:0], sda};
          goto_phase(PH_RX_HI);
        end
      end
      PH_RX_HI: begin
        if (half_period_done()) begin
          scl_q = 1'b0;
          if (bit_idx >= 4'd7) begin
            rx_q = shreg;
            oe_q = 1'b1;
            sda_q = !ack_sel;
            goto_phase(PH_AK_LO);
          end else begin
            bit_idx = bit_idx + 4'd1;
            goto_phase(PH_RX_LO);
          end
        end
      end
      PH_AK_LO: begin
        if (half_period_done()) begin
          scl_q = 1'b1;
          goto_phase(PH_AK_HI);
        end
      end
      PH_AK_HI: begin
        if (half_period_done()) begin
          scl_q = 1'b0;
          goto_phase(PH_IDLE);
          ended = 1'b1;
        end
      end
      PH_WA_A: begin
        if (half_period_done()) begin
          scl_q = 1'b1;
          goto_phase(PH_WA_B);
        end
      end
      PH_WA_B: begin
        if (half_period_done()) begin
          poll_count = 8'd0;
          goto_phase(PH_WA_POLL);
        end
      end
      PH_WA_POLL: begin
        if (!sda) begin
          scl_q = 1'b0;
          nack_q = 1'b0;
          goto_phase(PH_IDLE);
          ended = 1'b1;
        end else if (poll_count >= cfg_timeout) begin
          nack_q = 1'b1;
          n_timeouts++;
          open_stop();
        end else begin
          poll_count = poll_count + 8'd1;
        end
      end
      default: goto_phase(PH_IDLE);
    endcase
    return ended;
  endfunction

  function automatic line_state_t predict_word(bus_word_t w);
    line_state_t r;
    bit ended;
    bit turned_away;
    ended = 1'b0;
    turned_away = 1'b0;
    case (w.func)
      FN_TICK: begin
        if (seq_phase != PH_IDLE) ended = clock_tick(w.sda_in);
      end
      FN_START, FN_STOP, FN_SEND, FN_READ, FN_WAIT_ACK: begin
        if (seq_phase != PH_IDLE) begin
          turned_away = 1'b1;
        end else begin
          div_count = 8'd0;
          bit_idx = 4'd0;
          case (w.func)
            FN_START: begin
              oe_q = 1'b1;
              sda_q = 1'b1;
              scl_q = 1'b1;
              goto_phase(PH_ST_A);
            end
            FN_STOP: open_stop();
            FN_SEND: begin
              oe_q = 1'b1;
              shreg = w.data_byte;
              shift_out_bit();
              scl_q = 1'b1;
              goto_phase(PH_TX_HI);
            end
            FN_READ: begin
              oe_q = 1'b0;
              sda_q = 1'b1;
              scl_q = 1'b0;
              shreg = 8'd0;
              ack_sel = w.send_ack;
              goto_phase(PH_RX_LO);
            end
            default: begin
              oe_q = 1'b0;
              sda_q = 1'b1;
              nack_q = 1'b0;
              poll_count = 8'd0;
              goto_phase(PH_WA_A);
            end
          endcase
        end
      end
      default: ;
    endcase
    if (ended) n_done++;
    if (turned_away) n_rej++;
    r.scl = scl_q;
    r.sda = sda_q;
    r.sda_oe = oe_q;
    r.busy = (seq_phase != PH_IDLE);
    r.done = ended;
    r.rx = rx_q;
    r.ack_missing = nack_q;
    r.rejected = turned_away;
    return r;
  endfunction

  function automatic void reset_model();
    seq_phase = PH_IDLE;
    bit_idx = 4'd0;
    shreg = 8'd0;
    poll_count = 8'd0;
    div_count = 8'd0;
    scl_q = 1'b1;
    sda_q = 1'b1;
    oe_q = 1'b1;
    nack_q = 1'b0;
    ack_sel = 1'b0;
    rx_q = 8'd0;
    cfg_timeout = ACK_TIMEOUT_RST;
    cfg_tpp = TICKS_PER_PHASE_RST;
  endfunction

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      n_errors++;
    end
  endtask

  function automatic void push_word(logic [2:0] f, logic [7:0] d, logic a, logic s);
    bus_word_t w;
    w.func = f;
    w.data_byte = d;
    w.send_ack = a;
    w.sda_in = s;
    pending_words.push_back(w);
    if (f <= FN_WAIT_ACK) n_queued++;
  endfunction

  // One command followed by the ticks that carry it to its end, with the odd
  // stray command mixed in and now and then the tail cut off.
  function automatic void queue_sequence();
    logic [2:0]  cmd;
    logic [7:0]  data;
    bit          sda_seq[$];
    int unsigned tpp;
    int unsigned n;
    int unsigned k;
    int unsigned cut;
    int unsigned r;
    cmd = 3'($urandom_range(FN_START, FN_WAIT_ACK));
    tpp = (cfg_tpp == 8'd0) ? 1 : cfg_tpp;
    case (cmd)
      FN_SEND: n = 16 * tpp;
      FN_READ: n = 18 * tpp;
      default: n = 2 * tpp;
    endcase
    repeat (n) sda_seq.push_back(1'($urandom_range(0, 1)));
    if (cmd == FN_WAIT_ACK) begin
      k = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3)
                                     : cfg_timeout + $urandom_range(0, 1);
      if (k <= cfg_timeout) begin
        repeat (k) sda_seq.push_back(1'b1);
        sda_seq.push_back(1'b0);
      end else begin
        repeat (cfg_timeout + 1) sda_seq.push_back(1'b1);
        repeat (2 * tpp) sda_seq.push_back(1'($urandom_range(0, 1)));
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(0, sda_seq.size());
      while (sda_seq.size() > cut) void'(sda_seq.pop_back());
    end
    r = $urandom_range(0, 3);
    data = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom);
    push_word(cmd, data, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    foreach (sda_seq[i]) begin
      if ($urandom_range(0, 19) == 0)
        push_word(3'($urandom_range(FN_START, FN_SPARE_HI)), 8'($urandom),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      push_word(FN_TICK, 8'($urandom), 1'($urandom_range(0, 1)), sda_seq[i]);
    end
    repeat ($urandom_range(0, 2))
      push_word(FN_TICK, 8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endfunction

  task automatic wait_quiet();
    while (pending_words.size() != 0 || in_if.valid || expected_lines.size() != 0)
      @(posedge clk);
  endtask

  task automatic settle_bus();
    wait_quiet();
    while (seq_phase != PH_IDLE) begin
      repeat (32) push_word(FN_TICK, 8'h00, 1'b0, 1'b0);
      wait_quiet();
    end
  endtask

  task automatic run_random(int unsigned n);
    int unsigned target;
    target = n_queued + n;
    while (n_queued < target) queue_sequence();
    settle_bus();
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_ACK_TIMEOUT) cfg_timeout = val;
    else cfg_tpp = val;
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      accepted = in_if.valid && in_if.ready;
      if (accepted) begin
        expected_lines.push_back(predict_word(cur_word));
        n_sent++;
        gap_left = src_burst ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 49) == 0) src_burst = !src_burst;
      end else if (!in_if.valid && gap_left > 0) begin
        gap_left--;
      end
      if ((accepted || !in_if.valid) && gap_left == 0 && pending_words.size() != 0) begin
        cur_word = pending_words.pop_front();
        in_if.valid <= 1'b1;
        in_if.func <= cur_word.func;
        in_if.data_byte <= cur_word.data_byte;
        in_if.send_ack <= cur_word.send_ack;
        in_if.sda_in <= cur_word.sda_in;
      end else if (accepted) begin
        in_if.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        n_checked++;
        if (expected_lines.size() == 0) begin
          $error("result word arrived with nothing expected");
          n_errors++;
        end else begin
          front_line = expected_lines.pop_front();
          check_field("scl_level", 8'(front_line.scl), 8'(out_if.scl_level));
          check_field("sda_level", 8'(front_line.sda), 8'(out_if.sda_level));
          check_field("sda_driven", 8'(front_line.sda_oe), 8'(out_if.sda_driven));
          check_field("busy_res", 8'(front_line.busy), 8'(out_if.busy_res));
          check_field("done_res", 8'(front_line.done), 8'(out_if.done_res));
          check_field("rx_byte", front_line.rx, out_if.rx_byte);
          check_field("ack_missing", 8'(front_line.ack_missing), 8'(out_if.ack_missing));
          check_field("rejected", 8'(front_line.rejected), 8'(out_if.rejected));
        end
        if (n_checked == LONG_HOLD_AT) hold_left = LONG_HOLD_CYCLES;
        else hold_left = sink_burst ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
      end else if (hold_left > 0) begin
        hold_left--;
      end
      out_if.ready <= (hold_left == 0);
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.func = FN_TICK;
    in_if.data_byte = 8'h00;
    in_if.send_ack = 1'b0;
    in_if.sda_in = 1'b0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = CFG_ACK_TIMEOUT;
    cfg_if.data = 8'h00;
    rst_n = 1'b0;
    reset_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    run_random(60);

    // A zero in either register must behave as the smallest useful setting.
    write_reg(CFG_ACK_TIMEOUT, 8'd0);
    write_reg(CFG_TICKS_PER_PHASE, 8'd0);
    push_word(FN_TICK, 8'h00, 1'b0, 1'b0);
    push_word(FN_SPARE_LO, 8'h5A, 1'b0, 1'b1);
    push_word(FN_SPARE_HI, 8'hFF, 1'b1, 1'b1);
    push_word(FN_START, 8'h00, 1'b0, 1'b0);
    push_word(FN_STOP, 8'hFF, 1'b1, 1'b1);
    repeat (2) push_word(FN_TICK, 8'h00, 1'b0, 1'b1);
    push_word(FN_WAIT_ACK, 8'h00, 1'b0, 1'b0);
    repeat (3) push_word(FN_TICK, 8'h00, 1'b0, 1'b1);
    repeat (2) push_word(FN_TICK, 8'h00, 1'b0, 1'b1);
    push_word(FN_WAIT_ACK, 8'h00, 1'b0, 1'b1);
    repeat (2) push_word(FN_TICK, 8'h00, 1'b0, 1'b1);
    push_word(FN_TICK, 8'h00, 1'b0, 1'b0);
    push_word(FN_STOP, 8'h00, 1'b0, 1'b0);
    repeat (2) push_word(FN_TICK, 8'hFF, 1'b1, 1'b1);
    settle_bus();

    write_reg(CFG_ACK_TIMEOUT, 8'd3);
    write_reg(CFG_TICKS_PER_PHASE, 8'd1);
    run_random(60);

    write_reg(CFG_ACK_TIMEOUT, 8'd255);
    write_reg(CFG_TICKS_PER_PHASE, 8'd2);
    run_random(80);

    write_reg(CFG_ACK_TIMEOUT, 8'd1);
    write_reg(CFG_TICKS_PER_PHASE, 8'd255);
    push_word(FN_START, 8'h00, 1'b0, 1'b0);
    settle_bus();

    wait_quiet();
    repeat (4) @(posedge clk);
    $display("Run covered %0d words in and %0d results out over five register settings.",
             n_sent, n_checked);
    $display("Sequences ended: %0d, commands turned away: %0d, ack timeouts: %0d.",
             n_done, n_rej, n_timeouts);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
